/* rtl/texture_slot_aging_cache_assert.svh */
// Assertion macros shared by the texture slot aging cache modules.
`ifndef TEXTURE_SLOT_AGING_CACHE_ASSERT_SVH
`define TEXTURE_SLOT_AGING_CACHE_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TSAC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define TSAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/tsac_pkg.sv */
// Package with types, constants and helpers of the texture slot aging cache.
package tsac_pkg;
  localparam int unsigned SlotsDef   = 32;
  localparam int unsigned RefAreaDef = 16384;
  localparam int unsigned IdW = 16;
  localparam int unsigned DimW = 13;
  localparam int unsigned AgeW = 8;
  localparam int unsigned IdxW = 5;
  localparam int unsigned CntW = 6;
  localparam logic [7:0] BindLimitRst = 8'd30;
  localparam logic [7:0] FreeLimitRst = 8'd100;

  typedef enum logic [1:0] {
    MODE_GET = 2'd0, MODE_SWEEP = 2'd1, MODE_FREE = 2'd2, MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OUT_HIT = 3'd0, OUT_RECYCLED = 3'd1, OUT_NEW = 3'd2, OUT_FULL = 3'd3,
    OUT_SWEPT = 3'd4, OUT_FREED = 3'd5, OUT_MISSING = 3'd6
  } outcome_e;

  localparam logic CFG_BIND = 1'b0;
  localparam logic CFG_FREE = 1'b1;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IdW-1:0]  surface_id;
    logic [DimW-1:0] surf_width;
    logic [DimW-1:0] surf_height;
    logic            dirty;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] slot_index;
    logic [2:0]      outcome;
    logic            upload;
    logic [CntW-1:0] changed_count;
  } rsp_t;

  // Entry of the slot RAM.
  typedef struct packed {
    logic [IdW-1:0]  surface;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [AgeW-1:0] age;
  } entry_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start;      // latch request, reset scan
    logic rd;         // issue read of current slot
    logic eval;       // evaluate read data of previous slot
    logic commit;     // perform write chosen for the item
    logic finish;     // form result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last;       // slot counter at last slot
  } sts_t;
endpackage

/* rtl/tsac_if.sv */
// Valid/ready channel interface carrying one payload beat.
interface tsac_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/texture_slot_aging_cache.sv */
// Top level of the texture slot aging cache.
//  channel  | dir | beat contents
//  in_if    | in  | mode, surface_id, surf_width, surf_height, dirty
//  out_if   | out | slot_index, outcome, upload, changed_count
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (bind, free limit)
// Every item scans the whole slot table once, one RAM read per cycle;
// the one read port of the slot RAM is what sets the length of the scan.
// One item is worked on at a time; a new beat is taken in the cycle after
// the result beat leaves.
// The output beat holds while out ready is low.
// Reset clears present flags, limits and controller state; slot contents
// are used only where their present flag is set and need no clearing.
module texture_slot_aging_cache #(
  parameter int unsigned Slots   = tsac_pkg::SlotsDef,
  parameter int unsigned RefArea = tsac_pkg::RefAreaDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsac_if.sink       in_if,
  tsac_if.source     out_if,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import tsac_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  tsac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsac_dp #(.Slots(Slots), .RefArea(RefArea)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (in_if.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp)
  );

  assign out_if.data = rsp;
endmodule

/* rtl/tsac_ram.sv */
// Generic RAM with one write port and one registered read port.
module tsac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/tsac_ctrl.sv */
// Controller state machine of the texture slot aging cache.
module tsac_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  tsac_pkg::sts_t sts_i,
  output tsac_pkg::cmd_t cmd_o
);
  import tsac_pkg::*;
  `include "texture_slot_aging_cache_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_SCAN = 5'b00010, ST_TAIL = 5'b00100,
    ST_DONE = 5'b01000, ST_OUT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read issue for slot n overlaps evaluation of slot n-1.
        cmd_o.rd   = 1'b1;
        cmd_o.eval = 1'b1;
        if (sts_i.last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.commit = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TSAC_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `TSAC_ASSERT_NEXT(a_start_scan, clk_i, rst_ni, cmd_o.start, state_q == ST_SCAN)
  `TSAC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o)
endmodule

/* rtl/tsac_dp.sv */
// Datapath of the texture slot aging cache: slot RAM, scan and result.
module tsac_dp #(
  parameter int unsigned Slots   = tsac_pkg::SlotsDef,
  parameter int unsigned RefArea = tsac_pkg::RefAreaDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tsac_pkg::cmd_t cmd_i,
  output tsac_pkg::sts_t sts_o,
  input  tsac_pkg::req_t req_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i,
  output tsac_pkg::rsp_t rsp_o
);
  import tsac_pkg::*;
  `include "texture_slot_aging_cache_assert.svh"

  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned AreaW = 2 * DimW;
  localparam logic [AreaW:0] Th2  = (AreaW+1)'(2 * RefArea);
  localparam logic [AreaW:0] Th4  = (AreaW+1)'(4 * RefArea);
  localparam logic [AreaW:0] Th9  = (AreaW+1)'(9 * RefArea);
  localparam logic [AreaW:0] Th16 = (AreaW+1)'(16 * RefArea);

  logic [7:0]    bind_lim_q, free_lim_q;
  req_t          req_q;
  logic [Slots-1:0] present_q;
  logic [AW-1:0] rd_ptr_q, ev_ptr_q;
  logic          ev_vld_q;

  // Scan results.
  logic          hit_q, rec_q, free_q;
  logic [AW-1:0] hit_idx_q, rec_idx_q, free_idx_q;
  entry_t        hit_ent_q, rec_ent_q;
  logic [CntW-1:0] cnt_q;
  rsp_t          rsp_q, rsp_d;

  entry_t        rdata, wdata, sw_wdata;
  logic          we, sw_we;
  logic [AW-1:0] waddr;
  logic          sw_drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bind_lim_q <= BindLimitRst;
      free_lim_q <= FreeLimitRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BIND) begin
        bind_lim_q <= cfg_data_i;
      end else begin
        free_lim_q <= cfg_data_i;
      end
    end
  end

  tsac_ram #(.Width($bits(entry_t)), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign sts_o.last = (rd_ptr_q == AW'(Slots - 1));

  // Sweep evaluation of the slot whose data just arrived.
  logic          ev_pres;
  logic [AreaW-1:0] area;
  logic [2:0]    cls;
  logic [7:0]    age_inc, lim, lim_div;
  always_comb begin
    ev_pres = present_q[ev_ptr_q];
    area = AreaW'(rdata.width) * AreaW'(rdata.height);
    priority if ({1'b0, area} < Th2) cls = 3'd1;
    else if ({1'b0, area} < Th4)  cls = 3'd2;
    else if ({1'b0, area} < Th9)  cls = 3'd3;
    else if ({1'b0, area} < Th16) cls = 3'd4;
    else cls = 3'd5;
    age_inc = (rdata.age == 8'hFF) ? rdata.age : rdata.age + 8'd1;
    lim = (rdata.surface != '0) ? bind_lim_q : free_lim_q;
    unique case (cls)
      3'd1: lim_div = lim;
      3'd2: lim_div = lim >> 1;
      3'd3: lim_div = 8'((16'(lim) * 16'd171) >> 9);
      3'd4: lim_div = lim >> 2;
      default: lim_div = 8'((16'(lim) * 16'd205) >> 10);
    endcase
    sw_wdata = rdata;
    sw_wdata.age = age_inc;
    sw_drop = 1'b0;
    if (age_inc > lim_div) begin
      if (rdata.surface != '0) sw_wdata.surface = '0;
      else sw_drop = 1'b1;
    end
    sw_we = cmd_i.eval && ev_vld_q && ev_pres &&
            (req_q.mode == MODE_SWEEP);
  end

  // Commit write for get and free.
  entry_t get_w;
  logic   get_we;
  logic [AW-1:0] get_a;
  logic   id_zero;
  always_comb begin
    id_zero = (req_q.surface_id == '0);
    get_w  = hit_ent_q;
    get_we = 1'b0;
    get_a  = hit_idx_q;
    if (hit_q) begin
      get_w.age = (hit_ent_q.age != '0) ? hit_ent_q.age - 8'd1 : hit_ent_q.age;
      get_we = 1'b1;
    end else if (rec_q) begin
      get_w = rec_ent_q;
      get_w.age = '0;
      get_w.surface = req_q.surface_id;
      get_a = rec_idx_q;
      get_we = 1'b1;
    end else if (free_q) begin
      get_w.surface = req_q.surface_id;
      get_w.width = req_q.surf_width;
      get_w.height = req_q.surf_height;
      get_w.age = '0;
      get_a = free_idx_q;
      get_we = 1'b1;
    end
    if (req_q.mode != MODE_GET || id_zero || !cmd_i.commit) get_we = 1'b0;
    if (req_q.mode == MODE_FREE && hit_q && !id_zero && cmd_i.commit) begin
      get_w.surface = '0;
      get_a = hit_idx_q;
      get_we = 1'b1;
    end
    we    = sw_we | get_we;
    waddr = sw_we ? ev_ptr_q : get_a;
    wdata = sw_we ? sw_wdata : get_w;
  end

  // Result beat of the item.
  always_comb begin
    rsp_d = '0;
    rsp_d.outcome = OUT_MISSING;
    unique case (mode_e'(req_q.mode))
      MODE_GET: begin
        if (!id_zero) begin
          if (hit_q) begin
            rsp_d.slot_index = IdxW'(hit_idx_q);
            rsp_d.outcome = OUT_HIT;
            rsp_d.upload = req_q.dirty;
          end else if (rec_q) begin
            rsp_d.slot_index = IdxW'(rec_idx_q);
            rsp_d.outcome = OUT_RECYCLED;
            rsp_d.upload = 1'b1;
          end else if (free_q) begin
            rsp_d.slot_index = IdxW'(free_idx_q);
            rsp_d.outcome = OUT_NEW;
            rsp_d.upload = 1'b1;
          end else begin
            rsp_d.outcome = OUT_FULL;
          end
        end
      end
      MODE_SWEEP: begin
        rsp_d.outcome = OUT_SWEPT;
        rsp_d.changed_count = cnt_q;
      end
      MODE_FREE: begin
        if (!id_zero && hit_q) begin
          rsp_d.slot_index = IdxW'(hit_idx_q);
          rsp_d.outcome = OUT_FREED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      rd_ptr_q <= '0;
      ev_ptr_q <= '0;
      ev_vld_q <= 1'b0;
      hit_q <= 1'b0;
      rec_q <= 1'b0;
      free_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.start) begin
        rd_ptr_q <= '0;
        ev_vld_q <= 1'b0;
        hit_q <= 1'b0;
        rec_q <= 1'b0;
        free_q <= 1'b0;
        cnt_q <= '0;
      end else begin
        ev_vld_q <= cmd_i.rd;
        ev_ptr_q <= rd_ptr_q;
        if (cmd_i.rd && !sts_o.last) rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (cmd_i.eval && ev_vld_q) begin
        if (req_q.mode == MODE_SWEEP) begin
          if (ev_pres && age_inc > lim_div) begin
            if (cnt_q != '1) cnt_q <= cnt_q + CntW'(1);
            if (sw_drop) present_q[ev_ptr_q] <= 1'b0;
          end
        end else begin
          if (ev_pres && rdata.surface == req_q.surface_id && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (ev_pres && rdata.surface == '0 && rdata.width == req_q.surf_width &&
              rdata.height == req_q.surf_height && !rec_q) begin
            rec_q <= 1'b1;
          end
          if (!ev_pres && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit && !id_zero) begin
        if (req_q.mode == MODE_GET && !hit_q && !rec_q && free_q) begin
          present_q[free_idx_q] <= 1'b1;
        end
        if (req_q.mode == MODE_FREE && hit_q) begin
          present_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_i;
    end
    if (cmd_i.eval && ev_vld_q && req_q.mode != MODE_SWEEP) begin
      if (ev_pres && rdata.surface == req_q.surface_id && !hit_q) begin
        hit_idx_q <= ev_ptr_q;
        hit_ent_q <= rdata;
      end
      if (ev_pres && rdata.surface == '0 && rdata.width == req_q.surf_width &&
          rdata.height == req_q.surf_height && !rec_q) begin
        rec_idx_q <= ev_ptr_q;
        rec_ent_q <= rdata;
      end
      if (!ev_pres && !free_q) begin
        free_idx_q <= ev_ptr_q;
      end
    end
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  `TSAC_ASSERT_IMP(a_one_write, clk_i, rst_ni, sw_we, !cmd_i.commit)
  `TSAC_ASSERT_NEXT(a_cnt_sat, clk_i, rst_ni, cnt_q == '1 && !cmd_i.start, cnt_q == '1)
  `TSAC_ASSERT_IMP(a_ptr_range, clk_i, rst_ni, 1'b1, rd_ptr_q <= AW'(Slots - 1))
endmodule
